[rtl/cpbt_pkg.sv]
`default_nettype none

package cpbt_pkg;

    localparam int unsigned ADDR_W = 48;

    // Opcodes as they arrive on the item port.
    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Classified command kinds; an unused opcode folds into a query.
    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] virt_addr;
    } t_cpbt_in;

    typedef struct packed {
        logic was_marked;
        logic block_known;
        logic table_full;
        logic block_freed;
    } t_cpbt_out;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] virt_addr;
    } t_cpbt_cmd;

endpackage

`default_nettype wire

[rtl/cpbt_front.sv]
`default_nettype none

module cpbt_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire cpbt_pkg::t_cpbt_in  i_item,
    input  wire logic                i_pop,
    output logic                     o_full,
    output logic                     o_q_valid,
    output cpbt_pkg::t_cpbt_cmd      o_q_cmd
);

    cpbt_pkg::t_cpbt_cmd r_slot [2];
    logic                r_wptr;
    logic                r_rptr;
    logic [1:0]          r_cnt;
    logic [1:0]          n_cnt;
    cpbt_pkg::t_cpbt_cmd cmd;

    // Classify the opcode.
    always_comb begin
        cmd.virt_addr = i_item.virt_addr;
        case (i_item.opcode)
            cpbt_pkg::OP_SET:   cmd.kind = cpbt_pkg::KIND_SET;
            cpbt_pkg::OP_CLEAR: cmd.kind = cpbt_pkg::KIND_CLEAR;
            cpbt_pkg::OP_QUERY: cmd.kind = cpbt_pkg::KIND_QUERY;
            default:            cmd.kind = cpbt_pkg::KIND_QUERY;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= cmd;
        end
    end

    assign o_full    = (r_cnt == 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_slot[r_rptr];

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0)
        else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2 || i_pop))
        else $error("queue pushed while full");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count beyond two entries");
`endif

endmodule

`default_nettype wire

[rtl/cpbt_back.sv]
`default_nettype none

module cpbt_back #(
    parameter int unsigned PAGE_SHIFT       = 12,
    parameter int unsigned BLOCK_PAGE_SHIFT = 15,
    parameter int unsigned WORD_BIT_SHIFT   = 6,
    parameter int unsigned NUM_SLOTS        = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire cpbt_pkg::t_cpbt_cmd  i_q_cmd,
    output logic                      o_pop,
    output logic                      o_clearing,
    output logic                      o_done,
    output cpbt_pkg::t_cpbt_out       o_result
);

    localparam int unsigned TAG_LSB = PAGE_SHIFT + BLOCK_PAGE_SHIFT;
    localparam int unsigned TAG_W   = cpbt_pkg::ADDR_W - TAG_LSB;
    localparam int unsigned SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned WIDX_N  = BLOCK_PAGE_SHIFT - WORD_BIT_SHIFT;
    localparam int unsigned WIDX_W  = (WIDX_N > 0) ? WIDX_N : 1;
    localparam int unsigned WORD_W  = 1 << WORD_BIT_SHIFT;
    localparam int unsigned CNT_W   = BLOCK_PAGE_SHIFT + 1;
    localparam int unsigned MEM_AW  = SLOT_W + WIDX_W;
    localparam int unsigned MEM_DEPTH = 1 << MEM_AW;
    localparam logic [WIDX_W-1:0] WORD_MASK = WIDX_W'((1 << WIDX_N) - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RMW   = 2'd2;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [MEM_AW-1:0]         r_clr_addr;

    logic                      r_valid [NUM_SLOTS];
    logic [TAG_W-1:0]          r_tag   [NUM_SLOTS];
    logic [CNT_W-1:0]          r_cnt   [NUM_SLOTS];
    logic [WORD_W-1:0]         r_mem   [MEM_DEPTH];

    // Lookup stage results, held for the read-modify-write cycle.
    logic [1:0]                r_kind;
    logic                      r_hit;
    logic                      r_free_ok;
    logic [SLOT_W-1:0]         r_sel;
    logic [TAG_W-1:0]          r_new_tag;
    logic [WORD_BIT_SHIFT-1:0] r_bitpos;
    logic [MEM_AW-1:0]         r_addr;
    logic [WORD_W-1:0]         r_rdata;

    logic                      r_done;
    cpbt_pkg::t_cpbt_out       r_out;

    // Lookup stage signals.
    logic [TAG_W-1:0]          lk_tag;
    logic [WIDX_W-1:0]         lk_widx;
    logic                      lk_hit;
    logic [SLOT_W-1:0]         lk_hit_idx;
    logic                      lk_free_ok;
    logic [SLOT_W-1:0]         lk_free_idx;
    logic [SLOT_W-1:0]         lk_sel;
    logic [MEM_AW-1:0]         lk_addr;
    logic                      lk_go;

    // Modify stage signals.
    logic [WORD_W-1:0]         bit_mask;
    logic                      was;
    logic                      do_inc;
    logic                      do_alloc;
    logic                      do_dec;
    logic                      do_free;
    logic                      mem_we;
    logic [MEM_AW-1:0]         mem_waddr;
    logic [WORD_W-1:0]         mem_wdata;
    cpbt_pkg::t_cpbt_out       res;

    assign lk_tag  = i_q_cmd.virt_addr[cpbt_pkg::ADDR_W-1:TAG_LSB];
    assign lk_widx = WIDX_W'(i_q_cmd.virt_addr >> (PAGE_SHIFT + WORD_BIT_SHIFT)) & WORD_MASK;

    // Match against every slot; lowest index wins for both searches.
    always_comb begin
        lk_hit      = 1'b0;
        lk_hit_idx  = '0;
        lk_free_ok  = 1'b0;
        lk_free_idx = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (r_valid[s] && r_tag[s] == lk_tag) begin
                lk_hit     = 1'b1;
                lk_hit_idx = SLOT_W'(s);
            end
            if (!r_valid[s]) begin
                lk_free_ok  = 1'b1;
                lk_free_idx = SLOT_W'(s);
            end
        end
    end

    assign lk_sel  = lk_hit ? lk_hit_idx : lk_free_idx;
    assign lk_addr = {lk_sel, lk_widx};
    assign lk_go   = (r_state == ST_IDLE) && i_q_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == MEM_AW'(MEM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_RMW;
                end
            end
            ST_RMW:  n_state = ST_IDLE;
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + MEM_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (lk_go) begin
            r_kind    <= i_q_cmd.kind;
            r_hit     <= lk_hit;
            r_free_ok <= lk_free_ok;
            r_sel     <= lk_sel;
            r_new_tag <= lk_tag;
            r_bitpos  <= i_q_cmd.virt_addr[PAGE_SHIFT +: WORD_BIT_SHIFT];
            r_addr    <= lk_addr;
        end
    end

    // Read-modify-write of the addressed bitmap word.
    always_comb begin
        bit_mask = WORD_W'(1) << r_bitpos;
        was      = r_hit && r_rdata[r_bitpos];
        do_inc   = 1'b0;
        do_alloc = 1'b0;
        do_dec   = 1'b0;
        do_free  = 1'b0;
        if (r_state == ST_RMW) begin
            if (r_kind == cpbt_pkg::KIND_SET) begin
                do_inc   = r_hit && !was;
                do_alloc = !r_hit && r_free_ok;
            end else if (r_kind == cpbt_pkg::KIND_CLEAR) begin
                do_dec  = r_hit && was;
                do_free = r_hit && was && (r_cnt[r_sel] == CNT_W'(1));
            end
        end
        res.was_marked  = was;
        res.block_known = r_hit;
        res.table_full  = (r_kind == cpbt_pkg::KIND_SET) && !r_hit && !r_free_ok;
        res.block_freed = do_free;
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = do_inc || do_alloc || do_dec;
            mem_waddr = r_addr;
            mem_wdata = do_dec ? (r_rdata & ~bit_mask) : (r_rdata | bit_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (lk_go) begin
            r_rdata <= r_mem[lk_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (do_alloc) begin
            r_valid[r_sel] <= 1'b1;
        end else if (do_free) begin
            r_valid[r_sel] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_alloc) begin
            r_tag[r_sel] <= r_new_tag;
            r_cnt[r_sel] <= CNT_W'(1);
        end else if (do_free) begin
            r_tag[r_sel] <= '0;
            r_cnt[r_sel] <= '0;
        end else if (do_inc) begin
            r_cnt[r_sel] <= r_cnt[r_sel] + CNT_W'(1);
        end else if (do_dec) begin
            r_cnt[r_sel] <= r_cnt[r_sel] - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == ST_RMW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RMW) begin
            r_out <= res;
        end
    end

    assign o_pop      = lk_go;
    assign o_clearing = (r_state == ST_CLEAR);
    assign o_done     = r_done;
    assign o_result   = r_out;

`ifndef SYNTHESIS
    a_full_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_out.table_full) |-> (!r_out.block_known && !r_out.was_marked))
        else $error("table_full reported on a known block");
    a_freed_was_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_out.block_freed) |-> (r_out.block_known && r_out.was_marked))
        else $error("slot freed without a marked page");
    a_rmw_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RMW) |=> (r_state == ST_IDLE))
        else $error("modify stage held longer than one cycle");
    a_done_after_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == ST_RMW))
        else $error("result strobe without a modify cycle");
    a_hit_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RMW) && r_hit) |-> r_valid[r_sel])
        else $error("hit slot lost its valid bit before modify");
`endif

endmodule

`default_nettype wire

[rtl/cow_page_bitmap_table_unit.sv]
`default_nettype none

// Copy-on-write page mark table.
// Input: drive start with an item (opcode, virt_addr); the item transfers at
// the rising edge where start is high and busy is low. Opcode set, clear or
// query acts on the mark of the page that holds virt_addr.
// Output: every item gives one result on o_result, marked by o_done for a
// single cycle. The receiver cannot stall: a result is shown once and gone.
// With an empty queue, an item passes the queue slot, the lookup registers
// and the read-modify-write state before o_done rises with its result.
// The back end takes no new item until it is done with the last: a lookup,
// then a read-modify-write of one bitmap word in a single-port memory.
// A two-entry queue sits between the decoder and the back end, so up to two
// items can be taken while an earlier one is still being worked on.
// Reset: slots come up invalid and a clearing pass zeroes the bitmap memory,
// all (2^SLOT_W) * 2^(BLOCK_PAGE_SHIFT - WORD_BIT_SHIFT) words of it, one word
// per cycle; busy stays high until it is done.
// A set that misses on a full table is dropped and reported as table_full.

module cow_page_bitmap_table_unit #(
    parameter int unsigned PAGE_SHIFT       = 12,
    parameter int unsigned BLOCK_PAGE_SHIFT = 15,
    parameter int unsigned WORD_BIT_SHIFT   = 6,
    parameter int unsigned NUM_SLOTS        = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire cpbt_pkg::t_cpbt_in  i_item,
    output logic                     o_done,
    output cpbt_pkg::t_cpbt_out      o_result
);

    logic                q_full;
    logic                q_valid;
    cpbt_pkg::t_cpbt_cmd q_cmd;
    logic                pop;
    logic                clearing;
    logic                push;

    // Hold off new items while the queue is full or the bitmap is being cleared.
    assign busy = q_full || clearing;
    assign push = start && !busy;

    cpbt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .i_pop     (pop),
        .o_full    (q_full),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd)
    );

    cpbt_back #(
        .PAGE_SHIFT       (PAGE_SHIFT),
        .BLOCK_PAGE_SHIFT (BLOCK_PAGE_SHIFT),
        .WORD_BIT_SHIFT   (WORD_BIT_SHIFT),
        .NUM_SLOTS        (NUM_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import cpbt_pkg::*;

    // Address split with the default parameters of the block.
    localparam int PG_SH    = 12;
    localparam int BLK_SH   = 15;
    localparam int WB_SH    = 6;
    localparam int SLOTS    = 16;
    localparam int TAG_W    = ADDR_W - PG_SH - BLK_SH;
    localparam int WIDX_W   = BLK_SH - WB_SH;
    localparam int WORDS    = 1 << WIDX_W;

    // The spare opcode is not named in the package; it acts as a query.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int RAND_ITEMS = 1100;
    localparam int TAG_POOL   = 24;
    localparam int PAGE_POOL  = 5;

    typedef struct {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        t_cpbt_out         res;
    } t_plan_row;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    logic       busy;
    t_cpbt_in   i_item  = '0;
    logic       o_done;
    t_cpbt_out  o_result;

    // Typed expectation that travels with the item currently on the port.
    bit         typed_on  = 1'b0;
    t_cpbt_out  typed_res = '0;

    // Shadow copy of the slot table and the mark words.
    logic [TAG_W-1:0] blk_tag   [SLOTS];
    bit               blk_valid [SLOTS];
    logic [15:0]      blk_count [SLOTS];
    bit   [63:0]      mark_words [SLOTS*WORDS];

    t_cpbt_out        expected_marks[$];
    int               errors = 0;

    logic [TAG_W-1:0] tag_pool  [TAG_POOL];
    logic [BLK_SH-1:0] page_pool [PAGE_POOL] = '{15'd0, 15'd1, 15'd63, 15'd64, 15'h7FFF};

    cow_page_bitmap_table_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one item to the shadow table and return what the block must report.
    function automatic t_cpbt_out mark_table_step(input t_cpbt_in it);
        t_cpbt_out         r;
        logic [TAG_W-1:0]  tg;
        logic [WIDX_W-1:0] widx;
        logic [WB_SH-1:0]  bpos;
        int                hit;
        int                spare_slot;
        int                wa;
        r          = '0;
        tg         = it.virt_addr[ADDR_W-1 -: TAG_W];
        widx       = it.virt_addr[PG_SH+WB_SH +: WIDX_W];
        bpos       = it.virt_addr[PG_SH +: WB_SH];
        hit        = -1;
        spare_slot = -1;
        wa         = 0;
        for (int s = 0; s < SLOTS; s++) begin
            if (hit < 0 && blk_valid[s] && blk_tag[s] == tg)
                hit = s;
            if (spare_slot < 0 && !blk_valid[s])
                spare_slot = s;
        end
        if (hit >= 0) begin
            r.block_known = 1'b1;
            wa            = hit * WORDS + widx;
            r.was_marked  = mark_words[wa][bpos];
        end
        case (it.opcode)
            OP_SET: begin
                if (hit >= 0) begin
                    if (!r.was_marked) begin
                        mark_words[wa][bpos] = 1'b1;
                        blk_count[hit]      = blk_count[hit] + 16'd1;
                    end
                end else if (spare_slot < 0) begin
                    r.table_full = 1'b1;
                end else begin
                    // Take the lowest free slot for the new block.
                    blk_valid[spare_slot] = 1'b1;
                    blk_tag[spare_slot]   = tg;
                    blk_count[spare_slot] = 16'd1;
                    mark_words[spare_slot * WORDS + widx][bpos] = 1'b1;
                end
            end
            OP_CLEAR: begin
                // A clear that misses or finds the bit already clear changes nothing.
                if (hit >= 0 && r.was_marked) begin
                    mark_words[wa][bpos] = 1'b0;
                    if (blk_count[hit] != 0)
                        blk_count[hit] = blk_count[hit] - 16'd1;
                    if (blk_count[hit] == 0) begin
                        blk_valid[hit] = 1'b0;
                        blk_tag[hit]   = '0;
                        r.block_freed  = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_field(input string fname, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %b actual %b", $time, fname, want, got);
            errors++;
        end
    endtask

    // Result checker and acceptance monitor. Both read the values present
    // before the edge, so neither races the driver's nonblocking updates.
    always @(posedge i_clk) begin
        t_cpbt_out want;
        t_cpbt_out got;
        if (i_rst_n) begin
            // Check the result first: it always belongs to an earlier transfer.
            if (o_done === 1'b1) begin
                got = o_result;
                if (expected_marks.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none actual %b",
                             $time, got);
                    errors++;
                end else begin
                    want = expected_marks.pop_front();
                    report_field("was_marked",  want.was_marked,  got.was_marked);
                    report_field("block_known", want.block_known, got.block_known);
                    report_field("table_full",  want.table_full,  got.table_full);
                    report_field("block_freed", want.block_freed, got.block_freed);
                end
            end
            // Record the transfer: always advance the shadow table, then let a
            // typed value from the directed table take the place of the prediction.
            if (start === 1'b1 && busy === 1'b0) begin
                want = mark_table_step(i_item);
                if (typed_on)
                    want = typed_res;
                expected_marks.push_back(want);
            end
        end
    end

    // Hold the item on the port until the block takes it.
    task automatic send_item(input t_cpbt_in it, input bit en, input t_cpbt_out val);
        start     <= 1'b1;
        i_item    <= it;
        typed_on  <= en;
        typed_res <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Drop start for a random gap with some probability, with junk on the item port.
    task automatic sender_gap(input int pct);
        if ($urandom_range(0, 99) < pct) begin
            start  <= 1'b0;
            i_item <= t_cpbt_in'({$urandom, $urandom});
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic [ADDR_W-1:0] block_addr(input logic [TAG_W-1:0] tg,
                                                     input logic [BLK_SH-1:0] pg);
        return {tg, pg, 12'($urandom)};
    endfunction

    initial begin
        t_plan_row plan[$];
        t_plan_row row;
        t_cpbt_in  it;
        int        idle_pct [4];
        int        r;

        // Phases: no gaps, sender idle, receiver stall (no effect here), both.
        idle_pct = '{0, 60, 0, 9};

        for (int s = 0; s < SLOTS; s++) begin
            blk_tag[s]   = '0;
            blk_valid[s] = 1'b0;
            blk_count[s] = '0;
        end

        // Blocks from the directed fill come back in the random part so that
        // they get freed; a few random tags and the extremes round out the pool.
        tag_pool[0] = '1;
        for (int k = 1; k <= 16; k++)
            tag_pool[k] = TAG_W'(k);
        tag_pool[17] = '0;
        for (int k = 18; k < TAG_POOL; k++)
            tag_pool[k] = TAG_W'($urandom);

        // Directed table: empty-table lookups, a set/clear round trip that
        // frees its slot, a clear that misses, the spare opcode, the top
        // address, then fill all slots and overflow with one more set.
        row = '{OP_QUERY, 48'h0,            1'b1, t_cpbt_out'(4'b0000)}; plan.push_back(row);
        row = '{OP_SET,   48'h0,            1'b1, t_cpbt_out'(4'b0000)}; plan.push_back(row);
        row = '{OP_QUERY, 48'h0,            1'b1, t_cpbt_out'(4'b1100)}; plan.push_back(row);
        row = '{OP_SET,   48'h0,            1'b1, t_cpbt_out'(4'b1100)}; plan.push_back(row);
        row = '{OP_SET,   48'h1000,         1'b0, t_cpbt_out'(4'b0000)}; plan.push_back(row);
        row = '{OP_CLEAR, 48'h1000,         1'b0, t_cpbt_out'(4'b0000)}; plan.push_back(row);
        row = '{OP_CLEAR, 48'h0FFF,         1'b1, t_cpbt_out'(4'b1101)}; plan.push_back(row);
        row = '{OP_CLEAR, 48'h0,            1'b1, t_cpbt_out'(4'b0000)}; plan.push_back(row);
        row = '{OP_SPARE, '1,               1'b1, t_cpbt_out'(4'b0000)}; plan.push_back(row);
        row = '{OP_SET,   '1,               1'b1, t_cpbt_out'(4'b0000)}; plan.push_back(row);
        row = '{OP_QUERY, 48'hFFFFFFFFF000, 1'b1, t_cpbt_out'(4'b1100)}; plan.push_back(row);
        for (int k = 1; k < SLOTS; k++) begin
            row = '{OP_SET, {TAG_W'(k), 27'd0}, 1'b0, t_cpbt_out'(4'b0000)};
            plan.push_back(row);
        end
        row = '{OP_SET,   {TAG_W'(16), 27'd0}, 1'b1, t_cpbt_out'(4'b0010)}; plan.push_back(row);

        // Hold reset, then release it; the block runs its clearing pass
        // with busy high, which the first transfer simply waits out.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n]) begin
            it.opcode    = plan[n].op;
            it.virt_addr = plan[n].addr;
            send_item(it, plan[n].typed, plan[n].res);
        end

        // Random part: mostly set/clear/query traffic on a small set of blocks
        // and pages so that slots fill, overflow and free again; now and then
        // an arbitrary page or a fully random address.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            sender_gap(idle_pct[n * 4 / RAND_ITEMS]);
            r = $urandom_range(0, 99);
            it.opcode = (r < 40) ? OP_SET : (r < 75) ? OP_CLEAR : (r < 90) ? OP_QUERY : OP_SPARE;
            if ($urandom_range(0, 31) == 0)
                it.virt_addr = ADDR_W'({$urandom, $urandom});
            else if ($urandom_range(0, 15) == 0)
                it.virt_addr = block_addr(tag_pool[$urandom_range(0, TAG_POOL-1)],
                                          BLK_SH'($urandom));
            else
                it.virt_addr = block_addr(tag_pool[$urandom_range(0, TAG_POOL-1)],
                                          page_pool[$urandom_range(0, PAGE_POOL-1)]);
            send_item(it, 1'b0, '0);
        end

        // Drain: wait for every outstanding result, then keep the clock running
        // to catch any stray strobe.
        start <= 1'b0;
        while (expected_marks.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Safety net well beyond the slowest correct run, clearing pass included.
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/cpbt_pkg.sv
rtl/cpbt_front.sv
rtl/cpbt_back.sv
rtl/cow_page_bitmap_table_unit.sv
bench/tb.sv
